/* hw/rtl/rat_pkg.sv */
// rat_pkg: shared types and constants of the region address translator
// used by rat_cell and region_address_translator, depends on nothing
`default_nettype none

package rat_pkg;

	localparam int ADDR_W = 64;
	localparam int IDX_W = 8;
	localparam int SLOT_W = 4;
	localparam int DEFAULT_TABLE_ENTRIES = 16;

	typedef enum logic [1:0] {
		CMD_REGISTER   = 2'd0,
		CMD_UNREGISTER = 2'd1,
		CMD_L2R        = 2'd2,
		CMD_R2L        = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NOT_FOUND  = 2'd1,
		STAT_TABLE_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_COMMIT
	} fsm_state_t;

	typedef enum logic [1:0] {
		UPD_INSERT,
		UPD_MODIFY,
		UPD_REMOVE
	} upd_op_t;

	// search beat handed from cell to cell
	typedef struct packed {
		logic              live;
		cmd_t              cmd;
		logic [ADDR_W-1:0] key;
		logic              base_hit;
		logic [IDX_W-1:0]  base_idx;
		logic [IDX_W-1:0]  base_rank;
		logic              free_hit;
		logic [IDX_W-1:0]  free_idx;
		logic              best_hit;
		logic [IDX_W-1:0]  best_idx;
		logic [IDX_W-1:0]  best_rank;
		logic [ADDR_W-1:0] best_val;
	} rat_search_t;

	// table update broadcast to every cell
	typedef struct packed {
		logic              en;
		upd_op_t           op;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] lbase;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] rbase;
		logic [IDX_W-1:0]  rank;
	} rat_update_t;

endpackage

`default_nettype wire

/* hw/rtl/rat_cell.sv */
// rat_cell: one table entry plus one stage of the search chain
// depends on rat_pkg
`default_nettype none

module rat_cell #(
	parameter int TABLE_ENTRIES = rat_pkg::DEFAULT_TABLE_ENTRIES,
	parameter int CELL_INDEX = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire rat_pkg::rat_search_t rec_in,
	output rat_pkg::rat_search_t rec_out,
	input  wire rat_pkg::rat_update_t upd,
	output logic                 entry_valid
);

	localparam int RW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [rat_pkg::IDX_W-1:0] MY_IDX = rat_pkg::IDX_W'(CELL_INDEX);

	logic                        valid_q;
	logic [rat_pkg::ADDR_W-1:0]  lbase_q;
	logic [rat_pkg::ADDR_W-1:0]  len_q;
	logic [rat_pkg::ADDR_W-1:0]  rbase_q;
	logic [RW-1:0]               rank_q;
	rat_pkg::rat_search_t        rec_q;
	rat_pkg::rat_search_t        rec_nxt;

	logic [rat_pkg::IDX_W-1:0]   rank_ext;
	logic [rat_pkg::ADDR_W-1:0]  from_addr;
	logic [rat_pkg::ADDR_W-1:0]  to_addr;
	logic [rat_pkg::ADDR_W-1:0]  offset;
	logic                        base_match;
	logic                        range_match;
	logic                        is_target;

	assign rank_ext = rat_pkg::IDX_W'(rank_q);
	assign is_target = (upd.idx == MY_IDX);

	always_comb begin
		from_addr = (rec_in.cmd == rat_pkg::CMD_L2R) ? lbase_q : rbase_q;
		to_addr = (rec_in.cmd == rat_pkg::CMD_L2R) ? rbase_q : lbase_q;
		offset = rec_in.key - from_addr;
		base_match = valid_q && (lbase_q == rec_in.key);
		range_match = valid_q && (offset < len_q) &&
			(!rec_in.best_hit || (rank_ext > rec_in.best_rank));
		rec_nxt = rec_in;
		if (base_match && !rec_in.base_hit) begin
			rec_nxt.base_hit = 1'b1;
			rec_nxt.base_idx = MY_IDX;
			rec_nxt.base_rank = rank_ext;
		end
		if (!valid_q && !rec_in.free_hit) begin
			rec_nxt.free_hit = 1'b1;
			rec_nxt.free_idx = MY_IDX;
		end
		if (range_match) begin
			rec_nxt.best_hit = 1'b1;
			rec_nxt.best_idx = MY_IDX;
			rec_nxt.best_rank = rank_ext;
			rec_nxt.best_val = to_addr + offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q.live <= 1'b0;
		end else begin
			rec_q <= rec_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.en) begin
			unique case (upd.op)
				rat_pkg::UPD_INSERT: begin
					if (is_target) valid_q <= 1'b1;
				end
				rat_pkg::UPD_REMOVE: begin
					if (is_target) valid_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en) begin
			unique case (upd.op)
				rat_pkg::UPD_INSERT: begin
					if (is_target) begin
						lbase_q <= upd.lbase;
						len_q <= upd.size;
						rbase_q <= upd.rbase;
						rank_q <= RW'(upd.rank);
					end
				end
				rat_pkg::UPD_MODIFY: begin
					if (is_target) begin
						len_q <= upd.size;
						rbase_q <= upd.rbase;
					end
				end
				rat_pkg::UPD_REMOVE: begin
					if (!is_target && valid_q && (rank_ext > upd.rank))
						rank_q <= rank_q - RW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign rec_out = rec_q;
	assign entry_valid = valid_q;

endmodule

`default_nettype wire

/* hw/rtl/region_address_translator.sv */
// region_address_translator: top level, request head, cell chain, commit and result register
// depends on rat_pkg and rat_cell
`default_nettype none

// Region table of TABLE_ENTRIES entries held in a row of cells. An accepted beat
// (register, unregister or translate) enters the head of the row and moves one
// cell per cycle; every cell checks its own entry and passes the best match so far
// along. At the end of the row the result is formed and, once the result register
// is free, written out while any table change is applied to all cells at once.
// An item passes the head register, the register of every cell, the pending result
// register and the result register; a stalled output holds it in the commit state.
// Items are handled one at a time, so the next input beat is taken only once the
// previous item has been committed. The table is empty right after reset, with no
// clearing pass. The next item is taken while a result still waits on the output.

module region_address_translator #(
	parameter int TABLE_ENTRIES = rat_pkg::DEFAULT_TABLE_ENTRIES
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [1:0]                        cmd,
	input  wire  [rat_pkg::ADDR_W-1:0]        near_base,
	input  wire  [rat_pkg::ADDR_W-1:0]        region_size,
	input  wire  [rat_pkg::ADDR_W-1:0]        far_base,
	input  wire  [rat_pkg::ADDR_W-1:0]        pointer,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [1:0]                        status,
	output logic                              hit,
	output logic [rat_pkg::ADDR_W-1:0]        mapped_addr,
	output logic [rat_pkg::SLOT_W-1:0]        slot
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	rat_pkg::fsm_state_t         st_q;
	rat_pkg::fsm_state_t         st_nxt;
	rat_pkg::rat_search_t        head_q;
	rat_pkg::rat_search_t        chain [TABLE_ENTRIES+1];
	rat_pkg::rat_search_t        tail;
	rat_pkg::rat_update_t        upd_q;
	rat_pkg::rat_update_t        upd_calc;
	rat_pkg::rat_update_t        upd_bus;
	logic [TABLE_ENTRIES-1:0]    valid_vec;
	logic [CW-1:0]               count_q;
	logic [rat_pkg::ADDR_W-1:0]  req_size_q;
	logic [rat_pkg::ADDR_W-1:0]  req_rbase_q;
	logic [1:0]                  pend_status_q;
	logic                        pend_hit_q;
	logic [rat_pkg::ADDR_W-1:0]  pend_conv_q;
	logic [rat_pkg::SLOT_W-1:0]  pend_slot_q;
	rat_pkg::status_t            res_status;
	logic                        res_hit;
	logic [rat_pkg::ADDR_W-1:0]  res_conv;
	logic [rat_pkg::IDX_W-1:0]   res_idx;
	logic                        in_beat;
	logic                        commit_go;
	logic                        out_free;

	assign in_beat = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign tail = chain[TABLE_ENTRIES];

	// next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			rat_pkg::FSM_IDLE:   if (in_valid) st_nxt = rat_pkg::FSM_SEARCH;
			rat_pkg::FSM_SEARCH: if (tail.live) st_nxt = rat_pkg::FSM_COMMIT;
			rat_pkg::FSM_COMMIT: if (out_free) st_nxt = rat_pkg::FSM_IDLE;
			default:             st_nxt = rat_pkg::FSM_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		commit_go = 1'b0;
		unique case (st_q)
			rat_pkg::FSM_IDLE:   in_ready = 1'b1;
			rat_pkg::FSM_SEARCH: begin
			end
			rat_pkg::FSM_COMMIT: commit_go = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rat_pkg::FSM_IDLE;
			head_q.live <= 1'b0;
		end else begin
			st_q <= st_nxt;
			head_q.live <= in_beat;
			if (in_beat) begin
				head_q.cmd <= rat_pkg::cmd_t'(cmd);
				head_q.key <= (cmd[1]) ? pointer : near_base;
				head_q.base_hit <= 1'b0;
				head_q.base_idx <= '0;
				head_q.base_rank <= '0;
				head_q.free_hit <= 1'b0;
				head_q.free_idx <= '0;
				head_q.best_hit <= 1'b0;
				head_q.best_idx <= '0;
				head_q.best_rank <= '0;
				head_q.best_val <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			req_size_q <= region_size;
			req_rbase_q <= far_base;
		end
	end

	assign chain[0] = head_q;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		rat_cell #(
			.TABLE_ENTRIES(TABLE_ENTRIES),
			.CELL_INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.rec_in(chain[i]),
			.rec_out(chain[i+1]),
			.upd(upd_bus),
			.entry_valid(valid_vec[i])
		);
	end

	// result and table change from the end of the row
	always_comb begin
		res_status = rat_pkg::STAT_OK;
		res_hit = 1'b0;
		res_conv = '0;
		res_idx = '0;
		upd_calc.en = 1'b0;
		upd_calc.op = rat_pkg::UPD_MODIFY;
		upd_calc.idx = '0;
		upd_calc.lbase = tail.key;
		upd_calc.size = req_size_q;
		upd_calc.rbase = req_rbase_q;
		upd_calc.rank = '0;
		unique case (tail.cmd)
			rat_pkg::CMD_REGISTER: begin
				priority if (tail.base_hit) begin
					upd_calc.en = 1'b1;
					upd_calc.op = rat_pkg::UPD_MODIFY;
					upd_calc.idx = tail.base_idx;
					res_idx = tail.base_idx;
				end else if (count_q >= CW'(TABLE_ENTRIES)) begin
					res_status = rat_pkg::STAT_TABLE_FULL;
				end else if (tail.free_hit) begin
					upd_calc.en = 1'b1;
					upd_calc.op = rat_pkg::UPD_INSERT;
					upd_calc.idx = tail.free_idx;
					upd_calc.rank = rat_pkg::IDX_W'(count_q);
					res_idx = tail.free_idx;
				end else begin
					res_status = rat_pkg::STAT_TABLE_FULL;
				end
			end
			rat_pkg::CMD_UNREGISTER: begin
				if (tail.base_hit) begin
					upd_calc.en = 1'b1;
					upd_calc.op = rat_pkg::UPD_REMOVE;
					upd_calc.idx = tail.base_idx;
					upd_calc.rank = tail.base_rank;
					res_idx = tail.base_idx;
				end else begin
					res_status = rat_pkg::STAT_NOT_FOUND;
				end
			end
			rat_pkg::CMD_L2R, rat_pkg::CMD_R2L: begin
				priority if (tail.key == '0) begin
					res_hit = 1'b1;
				end else if (tail.best_hit) begin
					res_hit = 1'b1;
					res_conv = tail.best_val;
					res_idx = tail.best_idx;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q.en <= 1'b0;
		end else if (st_q == rat_pkg::FSM_SEARCH && tail.live) begin
			upd_q <= upd_calc;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == rat_pkg::FSM_SEARCH && tail.live) begin
			pend_status_q <= res_status;
			pend_hit_q <= res_hit;
			pend_conv_q <= res_conv;
			pend_slot_q <= res_idx[rat_pkg::SLOT_W-1:0];
		end
	end

	always_comb begin
		upd_bus = upd_q;
		upd_bus.en = upd_q.en && commit_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (upd_bus.en) begin
			unique case (upd_bus.op)
				rat_pkg::UPD_INSERT: count_q <= count_q + CW'(1);
				rat_pkg::UPD_REMOVE: if (count_q != '0) count_q <= count_q - CW'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (commit_go) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			status <= pend_status_q;
			hit <= pend_hit_q;
			mapped_addr <= pend_conv_q;
			slot <= pend_slot_q;
		end
	end

	// occupancy count tracks the valid bits of the row
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		CW'($countones(valid_vec)) == count_q)
		else $error("entry count differs from number of valid entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	// a search beat reaches the end of the row only while searching
	a_tail_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tail.live |-> (st_q == rat_pkg::FSM_SEARCH))
		else $error("search beat at row end outside search");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |=> out_valid && (st_q == rat_pkg::FSM_IDLE))
		else $error("commit did not present a result");

endmodule

`default_nettype wire

/* tb/sv/region_table_tracker_pkg.sv */
// region_table_tracker_pkg: shadow copy of the region table and the queue of expected replies
// depends on rat_pkg for the command and status codes
`timescale 1ns / 100ps

package region_table_tracker_pkg;

	localparam int ADDR_W = rat_pkg::ADDR_W;
	localparam int SLOT_W = rat_pkg::SLOT_W;
	localparam int TABLE_SIZE = rat_pkg::DEFAULT_TABLE_ENTRIES;

	typedef struct packed {
		logic [1:0]        status;
		logic              hit;
		logic [ADDR_W-1:0] converted;
		logic [SLOT_W-1:0] slot;
	} xlat_reply_t;

	class region_table_tracker;
		bit                ent_valid[TABLE_SIZE];
		logic [ADDR_W-1:0] ent_lbase[TABLE_SIZE];
		logic [ADDR_W-1:0] ent_len[TABLE_SIZE];
		logic [ADDR_W-1:0] ent_rbase[TABLE_SIZE];
		int unsigned       ent_rank[TABLE_SIZE];
		int unsigned       n_entries;
		xlat_reply_t       pending_replies[$];
		int unsigned       errors;
		int unsigned       n_requests;
		int unsigned       n_hits;
		int unsigned       n_misses;
		int unsigned       n_full;
		int unsigned       n_not_found;

		function new();
			foreach (ent_valid[i]) begin
				ent_valid[i] = 1'b0;
				ent_rank[i] = 0;
			end
			n_entries = 0;
			errors = 0;
			n_requests = 0;
			n_hits = 0;
			n_misses = 0;
			n_full = 0;
			n_not_found = 0;
		endfunction

		function int find_region(logic [ADDR_W-1:0] base);
			for (int i = 0; i < TABLE_SIZE; i++) begin
				if (ent_valid[i] && ent_lbase[i] == base)
					return i;
			end
			return -1;
		endfunction

		// update the shadow table and queue the reply this beat must produce
		function void apply_request(rat_pkg::cmd_t op, logic [ADDR_W-1:0] lb,
				logic [ADDR_W-1:0] sz, logic [ADDR_W-1:0] rb, logic [ADDR_W-1:0] ptr);
			xlat_reply_t r;
			int k;
			int best;
			logic [ADDR_W-1:0] from_a;
			logic [ADDR_W-1:0] to_a;
			logic [ADDR_W-1:0] off;
			r = '0;
			r.status = rat_pkg::STAT_OK;
			n_requests++;
			case (op)
				rat_pkg::CMD_REGISTER: begin
					k = find_region(lb);
					if (k >= 0) begin
						ent_len[k] = sz;
						ent_rbase[k] = rb;
						r.slot = k[SLOT_W-1:0];
					end else if (n_entries >= TABLE_SIZE) begin
						r.status = rat_pkg::STAT_TABLE_FULL;
						n_full++;
					end else begin
						k = 0;
						while (ent_valid[k])
							k++;
						ent_valid[k] = 1'b1;
						ent_lbase[k] = lb;
						ent_len[k] = sz;
						ent_rbase[k] = rb;
						ent_rank[k] = n_entries;
						n_entries++;
						r.slot = k[SLOT_W-1:0];
					end
				end
				rat_pkg::CMD_UNREGISTER: begin
					k = find_region(lb);
					if (k < 0) begin
						r.status = rat_pkg::STAT_NOT_FOUND;
						n_not_found++;
					end else begin
						ent_valid[k] = 1'b0;
						for (int i = 0; i < TABLE_SIZE; i++) begin
							if (ent_valid[i] && ent_rank[i] > ent_rank[k])
								ent_rank[i]--;
						end
						if (n_entries > 0)
							n_entries--;
						r.slot = k[SLOT_W-1:0];
					end
				end
				default: begin
					if (ptr == '0) begin
						r.hit = 1'b1;
						n_hits++;
					end else begin
						best = -1;
						for (int i = 0; i < TABLE_SIZE; i++) begin
							if (ent_valid[i]) begin
								from_a = (op == rat_pkg::CMD_L2R) ? ent_lbase[i] : ent_rbase[i];
								to_a = (op == rat_pkg::CMD_L2R) ? ent_rbase[i] : ent_lbase[i];
								off = ptr - from_a;
								if (off < ent_len[i] &&
										(best < 0 || ent_rank[i] > ent_rank[best])) begin
									best = i;
									r.converted = to_a + off;
								end
							end
						end
						if (best >= 0) begin
							r.hit = 1'b1;
							r.slot = best[SLOT_W-1:0];
							n_hits++;
						end else begin
							n_misses++;
						end
					end
				end
			endcase
			pending_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
			if (want !== got) begin
				$display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(logic [1:0] st, logic h, logic [ADDR_W-1:0] conv,
				logic [SLOT_W-1:0] sl);
			xlat_reply_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t unexpected reply beat: expected none, actual status %h hit %h %h slot %h",
					$time, st, h, conv, sl);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			compare_field("status", 64'(want.status), 64'(st));
			compare_field("hit", 64'(want.hit), 64'(h));
			compare_field("mapped_addr", want.converted, conv);
			compare_field("slot", 64'(want.slot), 64'(sl));
		endfunction
	endclass

endpackage

/* tb/sv/region_address_translator_test.sv */
// region_address_translator_test: directed and random register, unregister and translate beats
// with random stalls on both sides; depends on rat_pkg, region_table_tracker_pkg and the rtl
`timescale 1ns / 100ps

module region_address_translator_test;

	localparam int ADDR_W = rat_pkg::ADDR_W;
	localparam int SLOT_W = rat_pkg::SLOT_W;
	localparam int TABLE_ENTRIES = rat_pkg::DEFAULT_TABLE_ENTRIES;
	localparam int ITEM_CYCLES = TABLE_ENTRIES + 4;
	localparam int RANDOM_ITEMS = 1330;
	localparam int POOL_SIZE = 24;
	localparam logic [ADDR_W-1:0] ALL_ONES = '1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        cmd;
	logic [ADDR_W-1:0] near_base;
	logic [ADDR_W-1:0] region_size;
	logic [ADDR_W-1:0] far_base;
	logic [ADDR_W-1:0] pointer;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        status;
	logic              hit;
	logic [ADDR_W-1:0] mapped_addr;
	logic [SLOT_W-1:0] slot;

	region_table_tracker_pkg::region_table_tracker tracker;
	bit                  steady;
	int unsigned         accepted;
	logic [ADDR_W-1:0]   lpool[POOL_SIZE];
	logic [ADDR_W-1:0]   rpool[POOL_SIZE];

	region_address_translator #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.near_base(near_base),
		.region_size(region_size),
		.far_base(far_base),
		.pointer(pointer),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.hit(hit),
		.mapped_addr(mapped_addr),
		.slot(slot)
	);

	always #5 clk = ~clk;

	function automatic logic [ADDR_W-1:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(input rat_pkg::cmd_t op, input logic [ADDR_W-1:0] lb,
			input logic [ADDR_W-1:0] sz, input logic [ADDR_W-1:0] rb,
			input logic [ADDR_W-1:0] ptr);
		int gap;
		gap = 0;
		while (!steady && gap < 10 && $urandom_range(0, 99) < 35)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		cmd = op;
		near_base = lb;
		region_size = sz;
		far_base = rb;
		pointer = ptr;
		do @(posedge clk); while (!in_ready);
		tracker.apply_request(op, lb, sz, rb, ptr);
		accepted++;
	endtask

	task automatic send_random(input int idx);
		rat_pkg::cmd_t op;
		int r;
		int reg_w;
		int unreg_w;
		int p;
		logic [ADDR_W-1:0] lb;
		logic [ADDR_W-1:0] sz;
		logic [ADDR_W-1:0] rb;
		logic [ADDR_W-1:0] ptr;
		reg_w = ((idx / 150) % 2 == 0) ? 55 : 20;
		unreg_w = ((idx / 150) % 2 == 0) ? 15 : 30;
		lb = rnd64();
		sz = rnd64();
		rb = rnd64();
		ptr = rnd64();
		r = $urandom_range(0, 99);
		if (r < reg_w)
			op = rat_pkg::CMD_REGISTER;
		else if (r < reg_w + unreg_w)
			op = rat_pkg::CMD_UNREGISTER;
		else
			op = $urandom_range(0, 1) ? rat_pkg::CMD_L2R : rat_pkg::CMD_R2L;
		case (op)
			rat_pkg::CMD_REGISTER: begin
				lb = lpool[$urandom_range(0, POOL_SIZE - 1)];
				r = $urandom_range(0, 99);
				if (r < 5)
					sz = '0;
				else if (r >= 10)
					sz = 64'($urandom_range(1, 'h1800));
				if ($urandom_range(0, 99) < 80)
					rb = rpool[$urandom_range(0, POOL_SIZE - 1)];
			end
			rat_pkg::CMD_UNREGISTER: begin
				if ($urandom_range(0, 99) < 90)
					lb = lpool[$urandom_range(0, POOL_SIZE - 1)];
			end
			default: begin
				r = $urandom_range(0, 99);
				p = $urandom_range(0, POOL_SIZE - 1);
				if (r < 5)
					ptr = '0;
				else if (r >= 15) begin
					ptr = (op == rat_pkg::CMD_L2R) ? lpool[p] : rpool[p];
					if ($urandom_range(0, 99) < 10)
						ptr = ptr + ALL_ONES;
					else
						ptr = ptr + 64'($urandom_range(0, 'h1fff));
				end
			end
		endcase
		send_request(op, lb, sz, rb, ptr);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_reply(status, hit, mapped_addr, slot);
	end

	// receiver side, with one long hold-off so the block backs up into its input
	initial begin : reply_sink
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && accepted >= 300) begin
				held = 1'b1;
				hold_left = 250;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (steady) begin
				out_ready = 1'b1;
			end else begin
				out_ready = ($urandom_range(0, 99) >= 35);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		tracker = new();
		steady = 1'b0;
		accepted = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = rat_pkg::CMD_REGISTER;
		near_base = '0;
		region_size = '0;
		far_base = '0;
		pointer = '0;
		lpool[0] = rnd64();
		rpool[0] = 64'hffff_ffff_ffff_c000;
		for (int i = 1; i < POOL_SIZE; i++) begin
			lpool[i] = (i < 12) ? lpool[0] + 64'(i * 'h800) : rnd64();
			rpool[i] = (i < 12) ? rpool[0] + 64'(i * 'h800) : rnd64();
		end
		lpool[22] = '0;
		lpool[23] = ALL_ONES;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, zero pointer, unknown base
		send_request(rat_pkg::CMD_L2R, rnd64(), rnd64(), rnd64(), '0);
		send_request(rat_pkg::CMD_R2L, rnd64(), rnd64(), rnd64(), ALL_ONES);
		send_request(rat_pkg::CMD_UNREGISTER, 64'h1000, rnd64(), rnd64(), rnd64());
		// remote range wrapping past zero
		send_request(rat_pkg::CMD_REGISTER, 64'h1000, 64'h100, 64'hffff_ffff_ffff_ff80,
			rnd64());
		send_request(rat_pkg::CMD_L2R, rnd64(), rnd64(), rnd64(), 64'h10ff);
		send_request(rat_pkg::CMD_L2R, rnd64(), rnd64(), rnd64(), 64'h1100);
		send_request(rat_pkg::CMD_R2L, rnd64(), rnd64(), rnd64(), 64'h10);
		// local range wrapping past zero
		send_request(rat_pkg::CMD_REGISTER, ALL_ONES, 64'h3, 64'h5000, rnd64());
		send_request(rat_pkg::CMD_L2R, rnd64(), rnd64(), rnd64(), 64'h1);
		// zero length holds nothing
		send_request(rat_pkg::CMD_REGISTER, 64'h2000, '0, 64'h3000, rnd64());
		send_request(rat_pkg::CMD_R2L, rnd64(), rnd64(), rnd64(), 64'h3000);
		// newest overlapping region wins, update keeps the age
		send_request(rat_pkg::CMD_REGISTER, 64'h1080, ALL_ONES, '0, rnd64());
		send_request(rat_pkg::CMD_L2R, rnd64(), rnd64(), rnd64(), 64'h10a0);
		send_request(rat_pkg::CMD_REGISTER, 64'h1000, 64'h200, 64'h7000, rnd64());
		send_request(rat_pkg::CMD_L2R, rnd64(), rnd64(), rnd64(), 64'h10a0);
		send_request(rat_pkg::CMD_L2R, rnd64(), rnd64(), rnd64(), 64'h107f);
		send_request(rat_pkg::CMD_UNREGISTER, 64'h1080, rnd64(), rnd64(), rnd64());
		send_request(rat_pkg::CMD_L2R, rnd64(), rnd64(), rnd64(), 64'h10a0);
		send_request(rat_pkg::CMD_R2L, rnd64(), rnd64(), rnd64(), '0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 700 && i < 900);
			send_random(i);
		end
		steady = 1'b0;
		@(negedge clk);
		in_valid = 1'b0;

		while (tracker.pending_replies.size() != 0)
			@(posedge clk);
		repeat (2 * ITEM_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d translation hits, %0d misses,",
			tracker.n_requests, tracker.n_hits, tracker.n_misses);
		$display("%0d table-full and %0d unknown-base replies",
			tracker.n_full, tracker.n_not_found);
		if (tracker.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/rat_pkg.sv
hw/rtl/rat_cell.sv
hw/rtl/region_address_translator.sv
tb/sv/region_table_tracker_pkg.sv
tb/sv/region_address_translator_test.sv
